FILE: sv/src_pkg.sv
// ----------------------------------------------------------------------------
// src_pkg: shared constants and types for the stereo rms compressor
// fixed widths, register indexes, reset values and the sequencer state type
// ----------------------------------------------------------------------------
package src_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS_DEF   = 16;
	localparam int ENV_BITS        = 48;
	localparam int GAIN_BITS       = 17;
	localparam int TH_BITS         = 17;
	localparam int MAKEUP_BITS     = 16;
	localparam int REG_BITS        = 16;
	localparam int IDX_BITS        = 3;
	localparam int CFG_DATA_BITS   = 17;

	localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 17'd65536;
	localparam logic [GAIN_BITS-1:0] GAIN_FLOOR = 17'd655;
	localparam logic [23:0]          RMS_FLOOR  = 24'd83;

	localparam logic [IDX_BITS-1:0] REG_ENABLE  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_THRESH  = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_RATIO   = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_MAKEUP  = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_ATTACK  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_RELEASE = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_RMS     = 3'd6;

	localparam logic [16:0] THRESH_RST  = 17'd6554;
	localparam logic [15:0] RATIO_RST   = 16'd49152;
	localparam logic [15:0] MAKEUP_RST  = 16'd4096;
	localparam logic [15:0] ATTACK_RST  = 16'd65263;
	localparam logic [15:0] RELEASE_RST = 16'd65522;
	localparam logic [15:0] RMS_RST     = 16'd65400;

	// sequencer states, one-hot
	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SQ   = 10'b0000000010,
		ST_ENV  = 10'b0000000100,
		ST_SQRT = 10'b0000001000,
		ST_DIVP = 10'b0000010000,
		ST_DIV  = 10'b0000100000,
		ST_TGT  = 10'b0001000000,
		ST_GAIN = 10'b0010000000,
		ST_OUT  = 10'b0100000000,
		ST_SEND = 10'b1000000000
	} state_t;

	// serial multiply control
	typedef struct packed {
		logic start;
	} smul_ctl_t;

endpackage

FILE: sv/src_smul.sv
// ----------------------------------------------------------------------------
// src_smul: bit-serial shift-and-add multiplier
// unsigned product, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module src_smul
	import src_pkg::*;
#(
	parameter int A_BITS = 48,
	parameter int B_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smul_ctl_t                ctl,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic [A_BITS+B_BITS-1:0] p,
	output logic                     done
);
	localparam int CNT_BITS = $clog2(B_BITS + 1);

	logic [A_BITS+B_BITS-1:0] acc_q;
	logic [A_BITS-1:0]        a_q;
	logic [B_BITS-1:0]        b_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [A_BITS:0]          psum;

	// add the multiplicand into the top of the accumulator, then shift right
	assign psum = {1'b0, acc_q[A_BITS+B_BITS-1:B_BITS]} + (b_q[0] ? {1'b0, a_q} : '0);

	// done pulses the cycle after the last step, when the product is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(B_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {psum, acc_q[B_BITS-1:1]};
			b_q   <= b_q >> 1;
		end
	end

	assign p    = acc_q;
	assign done = done_q;
endmodule

FILE: sv/src_sqrt.sv
// ----------------------------------------------------------------------------
// src_sqrt: digit-by-digit integer square root
// one result bit per cycle from a two-bit digit of the radicand
// ----------------------------------------------------------------------------
module src_sqrt
	import src_pkg::*;
#(
	parameter int IN_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [IN_BITS-1:0]   v,
	output logic [IN_BITS/2-1:0] root,
	output logic                 done
);
	localparam int R_BITS   = IN_BITS / 2;
	localparam int CNT_BITS = $clog2(R_BITS + 1);

	logic [IN_BITS-1:0]  v_q;
	logic [R_BITS+1:0]   rem_q;
	logic [R_BITS-1:0]   root_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [R_BITS+1:0]   trial;
	logic [R_BITS+1:0]   diff;

	// bring down two bits, try subtracting 4*root+1
	assign trial = {rem_q[R_BITS-1:0], v_q[IN_BITS-1 -: 2]};
	assign diff  = trial - {root_q, 2'b01};

	// done pulses the cycle after the last step, when the root is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(R_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 2;
			if (trial >= {root_q, 2'b01}) begin
				rem_q  <= diff;
				root_q <= {root_q[R_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				root_q <= {root_q[R_BITS-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

FILE: sv/src_div.sv
// ----------------------------------------------------------------------------
// src_div: restoring divider
// unsigned quotient, one bit per cycle, numerator msb first
// ----------------------------------------------------------------------------
module src_div
	import src_pkg::*;
#(
	parameter int N_BITS = 57,
	parameter int D_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [N_BITS-1:0] num,
	input  logic [D_BITS-1:0] den,
	output logic [N_BITS-1:0] quo,
	output logic              done
);
	localparam int CNT_BITS = $clog2(N_BITS + 1);

	logic [N_BITS-1:0]   q_q;
	logic [D_BITS:0]     rem_q;
	logic [D_BITS-1:0]   den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [D_BITS+1:0]   trial;

	// shift in the next numerator bit, subtract the divisor if it fits
	assign trial = {rem_q, q_q[N_BITS-1]};

	// done pulses the cycle after the last step, when the quotient is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(N_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {2'b00, den_q}) begin
				rem_q <= (D_BITS+1)'(trial - {2'b00, den_q});
				q_q   <= {q_q[N_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[D_BITS:0];
				q_q   <= {q_q[N_BITS-2:0], 1'b0};
			end
		end
	end

	assign quo  = q_q;
	assign done = done_q;
endmodule

FILE: sv/stereo_rms_compressor.sv
// ----------------------------------------------------------------------------
// stereo_rms_compressor: stereo-linked rms compressor, bit-serial datapath
// rms detector, square root, gain divide, gain smoother and makeup scaling
// ----------------------------------------------------------------------------
// path: when enabled, a beat runs the serial multiplies (32 steps each), the 24-step
//   square root and, only above threshold, the 57-step divide; when disabled it goes
//   straight to the output register and is offered the cycle after it is taken
// flow: one beat at a time; the next is taken the cycle after the result is
//   taken, so output stalls also hold off the input
// reset: arst_n clears the sequencer, registers to reset values, envelope to
//   zero and gain to unity
module stereo_rms_compressor
	import src_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = COEF_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [2*SAMPLE_BITS-1:0]   s_axis_tdata,  // right_in high, left_in low
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [2*SAMPLE_BITS-1:0]   m_axis_tdata,  // right_out high, left_out low
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [IDX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data
);
	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = COEF_BITS;
	localparam int MB   = 64;   // shared multiplier operand width
	localparam int MBB  = 32;
	localparam int NB   = 57;   // divide numerator bits
	localparam int RB   = ENV_BITS / 2;
	localparam int XSH  = 2 * SB - 47;

	// configuration registers
	logic                 enable_q;
	logic [TH_BITS-1:0]   thresh_q;
	logic [CB-1:0]        ratio_q, attack_q, release_q, rmsc_q;
	logic [MAKEUP_BITS-1:0] makeup_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			thresh_q  <= THRESH_RST;
			ratio_q   <= CB'(RATIO_RST);
			makeup_q  <= MAKEUP_RST;
			attack_q  <= CB'(ATTACK_RST);
			release_q <= CB'(RELEASE_RST);
			rmsc_q    <= CB'(RMS_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_THRESH:  thresh_q  <= cfg_data;
				REG_RATIO:   ratio_q   <= CB'(cfg_data[REG_BITS-1:0]);
				REG_MAKEUP:  makeup_q  <= cfg_data[MAKEUP_BITS-1:0];
				REG_ATTACK:  attack_q  <= CB'(cfg_data[REG_BITS-1:0]);
				REG_RELEASE: release_q <= CB'(cfg_data[REG_BITS-1:0]);
				REG_RMS:     rmsc_q    <= CB'(cfg_data[REG_BITS-1:0]);
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// sequencer
	state_t state_q;
	logic [3:0] step_q;
	logic signed [SB-1:0] xl_q, xr_q;
	logic [ENV_BITS-1:0]  env_q;
	logic [GAIN_BITS-1:0] gain_q, target_q;
	logic [MB+1:0]        acc_q;
	logic [RB-1:0]        rms_q;
	logic [2*SB-1:0]      out_q;

	smul_ctl_t        mctl;
	logic [MB-1:0]    ma;
	logic [MBB-1:0]   mb;
	logic [MB+MBB-1:0] mp;
	logic             mdone;
	logic             sq_start, sq_done, dv_start, dv_done;
	logic [RB-1:0]    sq_root;
	logic [NB-1:0]    dv_quo;

	src_smul #(.A_BITS(MB), .B_BITS(MBB)) u_mul (
		.clk, .arst_n, .ctl(mctl), .a(ma), .b(mb), .p(mp), .done(mdone));
	src_sqrt #(.IN_BITS(ENV_BITS)) u_sqrt (
		.clk, .arst_n, .start(sq_start), .v(env_q), .root(sq_root), .done(sq_done));

	logic [RB-1:0] th_ext;
	logic          over;
	logic [NB-1:0] dnum;
	assign th_ext = RB'({thresh_q, 7'd0});
	assign over   = (rms_q > th_ext) && (rms_q > RMS_FLOOR);
	assign dnum   = NB'({acc_q[40:0], 16'd0});

	src_div #(.N_BITS(NB), .D_BITS(RB)) u_div (
		.clk, .arst_n, .start(dv_start), .num(dnum), .den(rms_q),
		.quo(dv_quo), .done(dv_done));

	logic [SB-1:0] magl, magr;
	assign magl = xl_q[SB-1] ? SB'(-xl_q) : xl_q;
	assign magr = xr_q[SB-1] ? SB'(-xr_q) : xr_q;

	logic [CB:0]   alpha, alpha_c;
	logic          fall;
	assign fall    = target_q < gain_q;
	assign alpha   = {1'b0, fall ? attack_q : release_q};
	assign alpha_c = (CB+1)'(1 << CB) - alpha;

	logic [CB:0] rms_c;
	assign rms_c = (CB+1)'(1 << CB) - {1'b0, rmsc_q};

	// magnitude of the sample being scaled, and its sign
	logic [SB-1:0] smag;
	logic          sneg;
	assign sneg = step_q[0] ? xr_q[SB-1] : xl_q[SB-1];
	assign smag = step_q[0] ? magr : magl;

	// operand selection for the shared serial multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SQ: begin
				ma = MB'(step_q[0] ? magr : magl);
				mb = MBB'(step_q[0] ? magr : magl);
			end
			ST_ENV: begin
				if (step_q[0]) begin
					ma = MB'(acc_q);
					mb = MBB'(rms_c);
				end else begin
					ma = MB'(env_q);
					mb = MBB'(rmsc_q);
				end
			end
			ST_DIVP: begin
				ma = MB'(rms_q - th_ext);
				mb = MBB'(ratio_q);
			end
			ST_GAIN: begin
				ma = step_q[0] ? MB'(target_q) : MB'(gain_q);
				mb = step_q[0] ? MBB'(alpha_c) : MBB'(alpha);
			end
			ST_OUT: begin
				ma = step_q[1] ? MB'(smag) : MB'(gain_q);
				mb = step_q[1] ? MBB'(acc_q) : MBB'(makeup_q);
			end
			default: ;
		endcase
	end

	// rounded, saturated output of a magnitude product
	logic [MB+MBB-1:0] rnd_pos, rnd_neg;
	logic [SB-1:0]     sat_res;
	logic [MB+MBB-1:0] limp, limn;
	always_comb begin
		rnd_pos = (mp + (1 << 27)) >> 28;
		rnd_neg = (mp + ((1 << 27) - 1)) >> 28;
		limp    = (MB+MBB)'((1 << (SB-1)) - 1);
		limn    = (MB+MBB)'(1 << (SB-1));
		if (sneg) sat_res = (rnd_neg >= limn) ? SB'(limn) : SB'(-rnd_neg);
		else      sat_res = (rnd_pos >= limp) ? SB'(limp) : SB'(rnd_pos);
	end

	logic [MB+MBB-1:0] xsq;
	assign xsq = (XSH >= 0) ? ((MB+MBB)'(acc_q) + mp) >> XSH
	                       : ((MB+MBB)'(acc_q) + mp) << (-XSH);

	logic mstart_q;
	assign mctl.start = mstart_q;
	logic sqstart_q, dvstart_q;
	assign sq_start = sqstart_q;
	assign dv_start = dvstart_q;

	logic [GAIN_BITS:0] red_t;
	assign red_t = (dv_quo >> CB) >= NB'(GAIN_ONE) ? '0
	             : (GAIN_BITS+1)'(GAIN_ONE) - (GAIN_BITS+1)'(dv_quo >> CB);

	// first envelope product is held in a scratch register
	logic [ENV_BITS-1:0] envp_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_ENV && mdone && !step_q[0]) envp_q <= ENV_BITS'(mp >> CB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			env_q     <= '0;
			gain_q    <= GAIN_ONE;
			mstart_q  <= 1'b0;
			sqstart_q <= 1'b0;
			dvstart_q <= 1'b0;
		end else begin
			mstart_q  <= 1'b0;
			sqstart_q <= 1'b0;
			dvstart_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					xl_q <= s_axis_tdata[SB-1:0];
					xr_q <= s_axis_tdata[2*SB-1:SB];
					if (enable_q) begin
						state_q  <= ST_SQ;
						step_q   <= '0;
						acc_q    <= '0;
						mstart_q <= 1'b1;
					end else begin
						out_q   <= s_axis_tdata;
						state_q <= ST_SEND;
					end
				end
				// sum of squares, left then right
				ST_SQ: if (mdone) begin
					if (step_q[0]) begin
						acc_q    <= (MB+2)'(xsq);
						state_q  <= ST_ENV;
						step_q   <= '0;
						mstart_q <= 1'b1;
					end else begin
						acc_q    <= (MB+2)'(mp);
						step_q   <= 4'd1;
						mstart_q <= 1'b1;
					end
				end
				// env*c + xsq*(1-c), each floored
				ST_ENV: if (mdone) begin
					if (step_q[0]) begin
						env_q     <= ENV_BITS'(envp_q + ENV_BITS'(mp >> CB));
						state_q   <= ST_SQRT;
						sqstart_q <= 1'b1;
					end else begin
						step_q   <= 4'd1;
						mstart_q <= 1'b1;
					end
				end
				ST_SQRT: if (sq_done) begin
					rms_q   <= sq_root;
					state_q <= ST_TGT;
					step_q  <= '0;
				end
				ST_TGT: begin
					if (step_q == 4'd0) begin
						if (over) begin
							state_q  <= ST_DIVP;
							mstart_q <= 1'b1;
						end else begin
							target_q <= GAIN_ONE;
							state_q  <= ST_GAIN;
							step_q   <= '0;
							mstart_q <= 1'b1;
						end
					end
				end
				ST_DIVP: if (mdone) begin
					acc_q     <= (MB+2)'(mp);
					state_q   <= ST_DIV;
					dvstart_q <= 1'b1;
				end
				ST_DIV: if (dv_done) begin
					target_q <= (red_t < (GAIN_BITS+1)'(GAIN_FLOOR)) ? GAIN_FLOOR
					           : GAIN_BITS'(red_t);
					state_q  <= ST_GAIN;
					step_q   <= '0;
					mstart_q <= 1'b1;
				end
				// gain*a + target*(1-a), each floored
				ST_GAIN: if (mdone) begin
					if (step_q[0]) begin
						gain_q   <= GAIN_BITS'(acc_q + (MB+2)'(mp >> CB));
						state_q  <= ST_OUT;
						step_q   <= '0;
						mstart_q <= 1'b1;
					end else begin
						acc_q    <= (MB+2)'(mp >> CB);
						step_q   <= 4'd1;
						mstart_q <= 1'b1;
					end
				end
				// total gain, then left and right scaling
				ST_OUT: if (mdone) begin
					if (step_q[1]) begin
						if (step_q[0]) begin
							out_q[2*SB-1:SB] <= sat_res;
							state_q <= ST_SEND;
						end else begin
							out_q[SB-1:0] <= sat_res;
							step_q   <= 4'd3;
							mstart_q <= 1'b1;
						end
					end else begin
						acc_q    <= (MB+2)'(mp);
						step_q   <= 4'd2;
						mstart_q <= 1'b1;
					end
				end
				ST_SEND: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_SEND);
	assign m_axis_tdata  = out_q;
endmodule
